>>> sv/rgbhs_pkg.sv
package rgbhs_pkg;

  localparam int RGB_BITS     = 16;
  localparam int HUE_BITS     = 9;
  localparam int SAT_BITS     = 7;
  localparam int CHANNEL_BITS = 16;

  // Quotient bits: hue quotient is at most 60, saturation at most 100.
  localparam int QUO_BITS = 7;

  localparam int HUE_SCALE = 60;
  localparam int SAT_SCALE = 100;

  localparam logic [HUE_BITS:0] RED_BASE    = (HUE_BITS+1)'(0);
  localparam logic [HUE_BITS:0] GREEN_BASE  = (HUE_BITS+1)'(120);
  localparam logic [HUE_BITS:0] BLUE_BASE   = (HUE_BITS+1)'(240);
  localparam logic [HUE_BITS:0] FULL_CIRCLE = (HUE_BITS+1)'(360);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    sector_e sec;
    logic    neg;
    logic    grey;
    logic    black;
  } side_t;

endpackage

>>> sv/rgb_to_hue_saturation.sv
// RGB to hue/saturation converter.
// Input stream s_axis: one RGB sample per transaction, channels unsigned; only the
// low CHANNEL_BITS bits of each channel are used.
// Output stream m_axis: hue in degrees (0..359, 0 for grey) and saturation in
// percent (0..100, 0 for black or grey), one result per input transaction, in order.
// Throughput: one transaction per cycle when m_axis_tready stays high.
// Pipeline: 11 register stages (input register, max/min, constant scaling, 7 divider
// stages, output register), the input register loading at the accepting edge.
// The two restoring dividers, one quotient bit per stage, set the depth.
// Stall: the whole pipeline holds while a result waits with m_axis_tready low;
// bubbles in the pipe still advance into a free output register. Nothing is
// dropped or repeated.
// Reset: rst_ni low clears all valid bits; the pipeline comes up empty and
// s_axis_tready is high right after reset.
module rgb_to_hue_saturation #(
  parameter int CHANNEL_BITS = rgbhs_pkg::CHANNEL_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // red[15:0], green[31:16], blue[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // hue[8:0], saturation[15:9]
);

  localparam int RgbW  = rgbhs_pkg::RGB_BITS;
  localparam int HueW  = rgbhs_pkg::HUE_BITS;
  localparam int SatW  = rgbhs_pkg::SAT_BITS;
  localparam int QuoW  = rgbhs_pkg::QUO_BITS;
  localparam int ChanW = (CHANNEL_BITS < RgbW) ? CHANNEL_BITS : RgbW;
  localparam int NumW  = ChanW + QuoW;

  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Stage 0: input register
  logic             s0_vld_q;
  logic [ChanW-1:0] s0_r_q, s0_g_q, s0_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_r_q <= s_axis_tdata[ChanW-1:0];
      s0_g_q <= s_axis_tdata[RgbW+ChanW-1:RgbW];
      s0_b_q <= s_axis_tdata[2*RgbW+ChanW-1:2*RgbW];
    end
  end

  // Stage 1: max, min, sector, channel difference
  rgbhs_pkg::sector_e sec_d;
  logic [ChanW-1:0]   mx_d, mn_d, ca, cb;

  always_comb begin
    if (s0_r_q >= s0_g_q && s0_r_q >= s0_b_q) begin
      sec_d = rgbhs_pkg::SEC_RED;
      mx_d  = s0_r_q;
      ca    = s0_g_q;
      cb    = s0_b_q;
    end else if (s0_g_q >= s0_b_q) begin
      sec_d = rgbhs_pkg::SEC_GREEN;
      mx_d  = s0_g_q;
      ca    = s0_b_q;
      cb    = s0_r_q;
    end else begin
      sec_d = rgbhs_pkg::SEC_BLUE;
      mx_d  = s0_b_q;
      ca    = s0_r_q;
      cb    = s0_g_q;
    end
    mn_d = s0_r_q;
    if (s0_g_q < mn_d) begin
      mn_d = s0_g_q;
    end
    if (s0_b_q < mn_d) begin
      mn_d = s0_b_q;
    end
  end

  logic               s1_vld_q;
  rgbhs_pkg::side_t   s1_side_q;
  logic [ChanW-1:0]   s1_mx_q, s1_d_q, s1_n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_side_q.sec   <= sec_d;
      s1_side_q.neg   <= ca < cb;
      s1_side_q.grey  <= mx_d == mn_d;
      s1_side_q.black <= mx_d == '0;
      s1_mx_q         <= mx_d;
      s1_d_q          <= mx_d - mn_d;
      s1_n_q          <= (ca >= cb) ? (ca - cb) : (cb - ca);
    end
  end

  // Stage 2: constant scaling of the numerators
  logic             s2_vld_q;
  rgbhs_pkg::side_t s2_side_q;
  logic [ChanW-1:0] s2_mx_q, s2_d_q;
  logic [NumW-1:0]  s2_hn_q, s2_sn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_side_q <= s1_side_q;
      s2_mx_q   <= s1_mx_q;
      s2_d_q    <= s1_d_q;
      s2_hn_q   <= NumW'(s1_n_q) * NumW'(rgbhs_pkg::HUE_SCALE);
      s2_sn_q   <= NumW'(s1_d_q) * NumW'(rgbhs_pkg::SAT_SCALE);
    end
  end

  // Divider stages
  logic [QuoW-1:0] hq, sq;

  rgbhs_div #(
    .DEN_W(ChanW),
    .QUO_W(QuoW)
  ) u_hue_div (
    .clk_i(clk_i),
    .en_i (adv),
    .num_i(s2_hn_q),
    .den_i(s2_d_q),
    .quo_o(hq)
  );

  rgbhs_div #(
    .DEN_W(ChanW),
    .QUO_W(QuoW)
  ) u_sat_div (
    .clk_i(clk_i),
    .en_i (adv),
    .num_i(s2_sn_q),
    .den_i(s2_mx_q),
    .quo_o(sq)
  );

  logic [QuoW-1:0]  dv_vld_q;
  rgbhs_pkg::side_t dv_side_q [QuoW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= '0;
    end else if (adv) begin
      dv_vld_q <= {dv_vld_q[QuoW-2:0], s2_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_side_q[0] <= s2_side_q;
      for (int k = 1; k < QuoW; k++) begin
        dv_side_q[k] <= dv_side_q[k-1];
      end
    end
  end

  // Output stage: sector offset and wrap
  rgbhs_pkg::side_t  fs;
  logic [HueW:0]     base, q_ext, hue_d;
  logic [SatW-1:0]   sat_d;

  assign fs    = dv_side_q[QuoW-1];
  assign q_ext = (HueW+1)'(hq);

  always_comb begin
    case (fs.sec)
      rgbhs_pkg::SEC_RED:   base = rgbhs_pkg::RED_BASE;
      rgbhs_pkg::SEC_GREEN: base = rgbhs_pkg::GREEN_BASE;
      rgbhs_pkg::SEC_BLUE:  base = rgbhs_pkg::BLUE_BASE;
      default:              base = rgbhs_pkg::RED_BASE;
    endcase
    if (fs.grey) begin
      hue_d = '0;
    end else if (!fs.neg) begin
      hue_d = base + q_ext;
    end else if (q_ext > base) begin
      hue_d = base + rgbhs_pkg::FULL_CIRCLE - q_ext;
    end else begin
      hue_d = base - q_ext;
    end
    sat_d = fs.black ? '0 : sq[SatW-1:0];
  end

  logic [HueW-1:0] hue_q;
  logic [SatW-1:0] sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= dv_vld_q[QuoW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hue_q <= hue_d[HueW-1:0];
      sat_q <= sat_d;
    end
  end

  assign m_axis_tdata = {sat_q, hue_q};

endmodule

>>> sv/rgbhs_div.sv
module rgbhs_div #(
  parameter int DEN_W = rgbhs_pkg::CHANNEL_BITS,
  parameter int QUO_W = rgbhs_pkg::QUO_BITS
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [DEN_W+QUO_W-1:0] num_i,
  input  logic [DEN_W-1:0]       den_i,
  output logic [QUO_W-1:0]       quo_o
);

  localparam int NumW = DEN_W + QUO_W;

  // Restoring division, one quotient bit per stage, MSB first.
  // Caller guarantees num < den << QUO_W.
  logic [NumW-1:0]  rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    localparam int Sh = QUO_W - 1 - k;

    logic [NumW-1:0]  rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [NumW-1:0]  den_sh;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign den_sh = NumW'(den_in) << Sh;
    assign ge     = rem_in >= den_sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? (rem_in - den_sh) : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= quo_in | (QUO_W'(ge) << Sh);
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

>>> sim/rgb_to_hue_saturation_tb.sv
module rgb_to_hue_saturation_tb;

  typedef struct packed {
    logic [rgbhs_pkg::RGB_BITS-1:0] blue;
    logic [rgbhs_pkg::RGB_BITS-1:0] green;
    logic [rgbhs_pkg::RGB_BITS-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [rgbhs_pkg::SAT_BITS-1:0] sat;
    logic [rgbhs_pkg::HUE_BITS-1:0] hue;
  } hue_sat_t;

  typedef struct {
    rgb_t px;
    bit   drain;
  } pixel_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // red[15:0], green[31:16], blue[47:32]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // hue[8:0], saturation[15:9]

  pixel_item_t pixel_q[$];
  hue_sat_t    hue_sat_q[$];
  int          outstanding = 0;
  int          errors = 0;
  int          tx_gap = 0;
  int          tx_burst = 0;
  int          rx_stall = 0;
  int          rx_burst = 0;
  pixel_item_t tx_item;
  hue_sat_t    exp_hs;
  hue_sat_t    act_hs;

  rgb_to_hue_saturation dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic hue_sat_t predict_hue_sat(rgb_t px);
    longint unsigned mask, r, g, b, mx, mn, d, a, c, base, q, hue, sat, full;
    hue_sat_t res;
    mask = (64'd1 << rgbhs_pkg::CHANNEL_BITS) - 64'd1;
    full = 64'(rgbhs_pkg::FULL_CIRCLE);
    r = 64'(px.red) & mask;
    g = 64'(px.green) & mask;
    b = 64'(px.blue) & mask;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    // ties: red, then green, then blue
    if (mx == r) begin
      a = g; c = b; base = 64'(rgbhs_pkg::RED_BASE);
    end else if (mx == g) begin
      a = b; c = r; base = 64'(rgbhs_pkg::GREEN_BASE);
    end else begin
      a = r; c = g; base = 64'(rgbhs_pkg::BLUE_BASE);
    end
    if (d == 64'd0) begin
      hue = 64'd0;
    end else if (a >= c) begin
      hue = base + (64'(rgbhs_pkg::HUE_SCALE) * (a - c)) / d;
    end else begin
      q = (64'(rgbhs_pkg::HUE_SCALE) * (c - a)) / d;
      hue = (q > base) ? base + full - q : base - q;
    end
    if (hue >= full) hue = hue - full;
    sat = (mx == 64'd0) ? 64'd0 : (64'(rgbhs_pkg::SAT_SCALE) * d) / mx;
    res.hue = hue[rgbhs_pkg::HUE_BITS-1:0];
    res.sat = sat[rgbhs_pkg::SAT_BITS-1:0];
    return res;
  endfunction

  // mostly no gap, some short, few long; occasional stretches with none
  function automatic int pick_gap(inout int burst);
    int sel;
    if (burst > 0) begin
      burst--;
      return 0;
    end
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    if (sel < 55) return 0;
    if (sel < 88) return $urandom_range(1, 3);
    if (sel < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b, bit drain = 0);
    pixel_item_t it;
    it.px.red = r;
    it.px.green = g;
    it.px.blue = b;
    it.drain = drain;
    pixel_q.push_back(it);
  endtask

  function automatic logic [15:0] edge_value();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'hFFFF;
      3: return 16'hFFFE;
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      tx_gap = 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (tx_gap > 0) begin
        tx_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() == 0 ||
                   (pixel_q[0].drain && (s_axis_tvalid || outstanding != 0))) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        tx_item = pixel_q.pop_front();
        s_axis_tdata  <= tx_item.px;
        s_axis_tvalid <= 1'b1;
        tx_gap = pick_gap(tx_burst);
      end
    end
  end

  // monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      outstanding   <= 0;
      rx_stall = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        act_hs = m_axis_tdata;
        if (hue_sat_q.size() == 0) begin
          $error("unexpected result transaction: hue %0d saturation %0d",
                 act_hs.hue, act_hs.sat);
          errors++;
        end else begin
          exp_hs = hue_sat_q.pop_front();
          if (act_hs.hue !== exp_hs.hue) begin
            $error("hue mismatch: expected %0d, actual %0d", exp_hs.hue, act_hs.hue);
            errors++;
          end
          if (act_hs.sat !== exp_hs.sat) begin
            $error("saturation mismatch: expected %0d, actual %0d", exp_hs.sat, act_hs.sat);
            errors++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) hue_sat_q.push_back(predict_hue_sat(s_axis_tdata));
      outstanding <= outstanding + int'(s_axis_tvalid && s_axis_tready)
                                 - int'(m_axis_tvalid && m_axis_tready);
      if (rx_stall > 0) begin
        rx_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        rx_stall = pick_gap(rx_burst);
      end
    end
  end

  initial begin
    #8_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int          kind;
    logic [15:0] v, r, g, b;
    // directed
    add_pixel(16'h0000, 16'h0000, 16'h0000);      // black
    add_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);      // white, grey
    add_pixel(16'h1234, 16'h1234, 16'h1234);      // grey
    add_pixel(16'h0001, 16'h0000, 16'h0000);
    add_pixel(16'hFFFF, 16'h0000, 16'h0000);      // pure red
    add_pixel(16'h0000, 16'hFFFF, 16'h0000);      // pure green
    add_pixel(16'h0000, 16'h0000, 16'hFFFF);      // pure blue
    add_pixel(16'hFFFF, 16'hFFFF, 16'h0000);      // red/green tie
    add_pixel(16'hFFFF, 16'h0000, 16'hFFFF);      // red/blue tie
    add_pixel(16'h0000, 16'hFFFF, 16'hFFFF);      // green/blue tie
    add_pixel(16'h0100, 16'h0100, 16'h0080);
    add_pixel(16'h0100, 16'h0080, 16'h0100);
    add_pixel(16'h0080, 16'h0100, 16'h0100);
    add_pixel(16'd100, 16'd0, 16'd2);             // red sector wraps to 359
    add_pixel(16'd1000, 16'd0, 16'd1);            // negative, zero magnitude
    add_pixel(16'hFFFF, 16'h0000, 16'h0001);
    add_pixel(16'hFFFF, 16'h8000, 16'h0000);
    add_pixel(16'h4000, 16'hFFFF, 16'h8000);      // green sector, positive
    add_pixel(16'h8000, 16'hFFFF, 16'h4000);      // green sector, negative
    add_pixel(16'h4000, 16'h8000, 16'hFFFF);      // blue sector, negative
    add_pixel(16'h8000, 16'h4000, 16'hFFFF);      // blue sector, positive
    add_pixel(16'd100, 16'd1, 16'd50);            // saturation 99
    add_pixel(16'hFFFE, 16'hFFFF, 16'hFFFE);
    add_pixel(16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
    // random
    for (int i = 0; i < 850; i++) begin
      kind = $urandom_range(0, 9);
      r = 16'($urandom_range(0, 16'hFFFF));
      g = 16'($urandom_range(0, 16'hFFFF));
      b = 16'($urandom_range(0, 16'hFFFF));
      case (kind)
        5: begin
          r = 16'($urandom_range(0, 15));
          g = 16'($urandom_range(0, 15));
          b = 16'($urandom_range(0, 15));
        end
        6: begin
          g = r;
          b = r;
        end
        7: begin
          v = 16'($urandom_range(0, 16'hFFFF));
          case ($urandom_range(0, 2))
            0: begin r = v; g = v; b = 16'($urandom_range(0, 32'(v))); end
            1: begin r = v; b = v; g = 16'($urandom_range(0, 32'(v))); end
            default: begin g = v; b = v; r = 16'($urandom_range(0, 32'(v))); end
          endcase
        end
        8: begin
          v = 16'($urandom_range(256, 16'hFFFF));
          r = v - 16'($urandom_range(0, 255));
          g = v - 16'($urandom_range(0, 255));
          b = v - 16'($urandom_range(0, 255));
        end
        9: begin
          r = edge_value();
          g = edge_value();
          b = edge_value();
        end
        default: ;
      endcase
      add_pixel(r, g, b, (i == 300) || (i == 600));
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (pixel_q.size() != 0 || s_axis_tvalid || outstanding != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (hue_sat_q.size() != 0) begin
      $error("%0d expected results never arrived", hue_sat_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
